// ===== hw/rtl/ousk_pkg.sv =====
// ----------------------------------------------------------------------------
// ousk_pkg
// Types and codes shared by the ordered unique key set unit and its cells.
// ----------------------------------------------------------------------------
package ousk_pkg;

   localparam int REQ_KEY_W = 32;
   localparam int RSP_KEY_W = 32;
   localparam int RSP_CNT_W = 5;

   typedef enum logic [1:0] {
      REQ_ADD      = 2'd0,
      REQ_REMOVE   = 2'd1,
      REQ_CONTAINS = 2'd2,
      REQ_DUMP     = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_UPDATE = 2'd2,
      ST_DUMP   = 2'd3
   } state_type;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [REQ_KEY_W-1:0] key;
   } req_beat_type;

   typedef struct packed {
      logic                 hit;
      logic                 full_refused;
      logic [RSP_CNT_W-1:0] entry_count;
      logic [RSP_KEY_W-1:0] entry_key;
      logic                 entry_valid;
      logic                 last;
   } rsp_beat_type;

   typedef struct packed {
      logic search;
      logic append;
      logic shift;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/ordered_unique_key_set_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_unique_key_set_unit
// Fixed-capacity set of distinct keys kept in insertion order in a chain of
// cells; add, remove, contains and an in-order dump of all keys.
// ----------------------------------------------------------------------------
// add, remove, contains: the cells register a match in the search state, and
//   the update state loads the response once the response register is free
// one request at a time, taken only in idle; a dump emits one key per cycle
//   while the response side accepts, stored-count beats (one beat when empty)
// reset: synchronous, clears the count and control; stored keys need no reset
// ----------------------------------------------------------------------------
module ordered_unique_key_set_unit
   import ousk_pkg::*;
#(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IN_W  = (KEY_WIDTH < REQ_KEY_W) ? KEY_WIDTH : REQ_KEY_W;
   localparam int OUT_W = (KEY_WIDTH < RSP_KEY_W) ? KEY_WIDTH : RSP_KEY_W;

   state_type            state_ff, state_in;
   logic [1:0]           kind_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     dump_idx_ff, dump_idx_in;
   logic                 rsp_valid_ff;
   rsp_beat_type         rsp_ff, rsp_in;
   logic                 rsp_load;

   cell_ctl_type         ctl;
   logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0]  match_vec;
   logic [CAPACITY:0]    carry;

   logic req_fire, slot_free, any_hit, is_full, dump_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign any_hit   = |match_vec;
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign dump_last = (count_ff == '0) ||
                      ((CNT_W'(dump_idx_ff) + CNT_W'(1)) == count_ff);

   // key chain
   assign carry[0] = 1'b0;
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] nbr_key;
      if (i + 1 < CAPACITY) begin : g_mid
         assign nbr_key = cell_key[i+1];
      end else begin : g_end
         assign nbr_key = '0;
      end
      ousk_cell #(
         .KEY_WIDTH (KEY_WIDTH),
         .CNT_W     (CNT_W),
         .IDX       (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .search_key (key_ff),
         .count      (count_ff),
         .next_key   (nbr_key),
         .carry_in   (carry[i]),
         .key_q      (cell_key[i]),
         .match_q    (match_vec[i]),
         .carry_out  (carry[i+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_payload.req_type == REQ_DUMP) ? ST_DUMP : ST_SEARCH;
            end
         end
         ST_SEARCH: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         ST_DUMP: begin
            if (slot_free && dump_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      ctl         = '0;
      rsp_load    = 1'b0;
      rsp_in      = '0;
      count_in    = count_ff;
      dump_idx_in = dump_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            dump_idx_in = '0;
         end
         ST_SEARCH: begin
            ctl.search = 1'b1;
         end
         ST_UPDATE: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_in.last = 1'b1;
               case (kind_ff)
                  REQ_ADD: begin
                     if (any_hit) begin
                        rsp_in.hit = 1'b1;
                     end else if (is_full) begin
                        rsp_in.full_refused = 1'b1;
                     end else begin
                        ctl.append = 1'b1;
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_REMOVE: begin
                     if (any_hit) begin
                        rsp_in.hit = 1'b1;
                        ctl.shift  = 1'b1;
                        count_in   = count_ff - CNT_W'(1);
                     end
                  end
                  default: rsp_in.hit = any_hit;
               endcase
               rsp_in.entry_count = RSP_CNT_W'(count_in);
            end
         end
         ST_DUMP: begin
            if (slot_free) begin
               rsp_load           = 1'b1;
               rsp_in.last        = dump_last;
               rsp_in.entry_count = RSP_CNT_W'(count_ff);
               if (count_ff != '0) begin
                  rsp_in.entry_valid = 1'b1;
                  rsp_in.entry_key   = RSP_KEY_W'(cell_key[dump_idx_ff][OUT_W-1:0]);
               end
               dump_idx_in = dump_idx_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dump_idx_ff <= dump_idx_in;
      if (req_fire) begin
         kind_ff <= req_payload.req_type;
         key_ff  <= KEY_WIDTH'(req_payload.key[IN_W-1:0]);
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored count beyond capacity");

   a_keys_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $onehot0(match_vec))
      else $error("more than one cell matched a key");

   a_count_only_on_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && ($past(state_ff) != ST_UPDATE)) |-> $stable(count_ff))
      else $error("count changed outside an update");

   a_dump_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_in.entry_valid) |-> (CNT_W'(dump_idx_ff) < count_ff))
      else $error("dump read past the stored keys");

endmodule

// ===== hw/rtl/ousk_cell.sv =====
// ----------------------------------------------------------------------------
// ousk_cell
// One key chain slot: holds a key, compares it to the broadcast key, stores it
// when appended at count, and on a remove takes next_key at or past a match.
// ----------------------------------------------------------------------------
module ousk_cell
   import ousk_pkg::*;
#(
   parameter int KEY_WIDTH = 32,
   parameter int CNT_W     = 5,
   parameter int IDX       = 0
) (
   input  logic                 clock,
   input  cell_ctl_type         ctl,
   input  logic [KEY_WIDTH-1:0] search_key,
   input  logic [CNT_W-1:0]     count,
   input  logic [KEY_WIDTH-1:0] next_key,
   input  logic                 carry_in,
   output logic [KEY_WIDTH-1:0] key_q,
   output logic                 match_q,
   output logic                 carry_out
);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 match_ff, match_in;
   logic                 occupied;

   assign occupied  = CNT_W'(IDX) < count;
   assign carry_out = carry_in | match_ff;

   always_comb begin
      match_in = match_ff;
      if (ctl.search) begin
         match_in = occupied && (key_ff == search_key);
      end
   end

   always_comb begin
      key_in = key_ff;
      if (ctl.append && (CNT_W'(IDX) == count)) begin
         key_in = search_key;
      end else if (ctl.shift && carry_out) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      match_ff <= match_in;
   end

   assign key_q   = key_ff;
   assign match_q = match_ff;

endmodule

// ===== tb/ousk_checker.sv =====
// ----------------------------------------------------------------------------
// ousk_checker
// Watches the request and response channels of the ordered unique key set
// unit, keeps its own copy of the stored keys in insertion order, predicts
// every response beat and compares each accepted response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ousk_checker
   import ousk_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_beat_type req_payload,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_beat_type rsp_payload,
   output int           fail_count,
   output int           pending_rsps
);

   logic [REQ_KEY_W-1:0] held_keys [CAPACITY];
   int                   held_count;
   rsp_beat_type         expected_rsps [$];

   initial begin
      fail_count   = 0;
      pending_rsps = 0;
      held_count   = 0;
   end

   task automatic predict_request(input req_beat_type beat);
      rsp_beat_type rsp;
      int           pos;
      int           i;
      pos = -1;
      for (i = 0; i < held_count; i++) begin
         if (pos < 0 && held_keys[i] == beat.key) begin
            pos = i;
         end
      end
      rsp      = '0;
      rsp.last = 1'b1;
      case (req_kind_type'(beat.req_type))
         REQ_DUMP: begin
            if (held_count == 0) begin
               expected_rsps = {expected_rsps, rsp};
            end else begin
               for (i = 0; i < held_count; i++) begin
                  rsp.entry_count = RSP_CNT_W'(held_count);
                  rsp.entry_key   = held_keys[i];
                  rsp.entry_valid = 1'b1;
                  rsp.last        = (i == held_count - 1);
                  expected_rsps   = {expected_rsps, rsp};
               end
            end
         end
         REQ_ADD: begin
            if (pos >= 0) begin
               rsp.hit = 1'b1;
            end else if (held_count >= CAPACITY) begin
               rsp.full_refused = 1'b1;
            end else begin
               held_keys[held_count] = beat.key;
               held_count++;
            end
            rsp.entry_count = RSP_CNT_W'(held_count);
            expected_rsps   = {expected_rsps, rsp};
         end
         REQ_REMOVE: begin
            if (pos >= 0) begin
               for (i = pos; i + 1 < held_count; i++) begin
                  held_keys[i] = held_keys[i + 1];
               end
               held_count--;
               rsp.hit = 1'b1;
            end
            rsp.entry_count = RSP_CNT_W'(held_count);
            expected_rsps   = {expected_rsps, rsp};
         end
         default: begin
            rsp.hit         = (pos >= 0);
            rsp.entry_count = RSP_CNT_W'(held_count);
            expected_rsps   = {expected_rsps, rsp};
         end
      endcase
   endtask

   task automatic report_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field,
                  exp_val, got_val);
         fail_count++;
      end
   endtask

   task automatic check_response(input rsp_beat_type got);
      rsp_beat_type exp;
      if (expected_rsps.size() == 0) begin
         $display("%0t: unexpected response beat, expected none, actual %h", $time, got);
         fail_count++;
      end else begin
         exp = expected_rsps.pop_front();
         report_field("hit", 32'(exp.hit), 32'(got.hit));
         report_field("full_refused", 32'(exp.full_refused), 32'(got.full_refused));
         report_field("entry_count", 32'(exp.entry_count), 32'(got.entry_count));
         report_field("entry_key", exp.entry_key, got.entry_key);
         report_field("entry_valid", 32'(exp.entry_valid), 32'(got.entry_valid));
         report_field("last", 32'(exp.last), 32'(got.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         expected_rsps.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_request(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            check_response(rsp_payload);
         end
      end
      pending_rsps <= expected_rsps.size();
   end

endmodule

// ===== tb/tb_ordered_unique_key_set_unit.sv =====
// ----------------------------------------------------------------------------
// tb_ordered_unique_key_set_unit
// Drives add, remove, contains and dump requests into the ordered unique key
// set unit: a directed pass over empty, full, duplicate and missing-key cases,
// then random requests over small key pools under varying idle rates on both
// channels, with a long response stall and a full drain. A checker module
// predicts and compares every response beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ordered_unique_key_set_unit
   import ousk_pkg::*;
();

   localparam int SET_CAPACITY = 16;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int LONG_HOLD    = 80;
   localparam int PHASE_ITEMS  = 127;
   localparam int POOL_SIZE    = 32;
   localparam int POOL_IDX_W   = $clog2(POOL_SIZE);

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   req_beat_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   rsp_beat_type rsp_payload;

   int fail_count;
   int pending_rsps;
   int cycle_count    = 0;
   int send_idle_pct  = 33;
   int rsp_idle_pct   = 52;
   int pool_span      = 12;
   int hold_requests  = 0;
   int holds_done     = 0;

   logic [REQ_KEY_W-1:0] key_pool [POOL_SIZE];

   ordered_unique_key_set_unit #(
      .CAPACITY  (SET_CAPACITY),
      .KEY_WIDTH (REQ_KEY_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   ousk_checker #(
      .CAPACITY (SET_CAPACITY)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .fail_count   (fail_count),
      .pending_rsps (pending_rsps)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response side, with a long stall on request
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_beat(input req_kind_type kind, input logic [REQ_KEY_W-1:0] key);
      req_valid            <= 1'b1;
      req_payload.req_type <= kind;
      req_payload.key      <= key;
      do @(posedge clock); while (!req_ready);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsps != 0);
   endtask

   task automatic send_random_item;
      req_kind_type         kind;
      logic [REQ_KEY_W-1:0] key;
      int                   roll;
      roll = $urandom_range(99);
      if (roll < 35) begin
         kind = REQ_ADD;
      end else if (roll < 60) begin
         kind = REQ_REMOVE;
      end else if (roll < 85) begin
         kind = REQ_CONTAINS;
      end else begin
         kind = REQ_DUMP;
      end
      if ($urandom_range(99) < 80) begin
         key = key_pool[POOL_IDX_W'($urandom_range(pool_span - 1))];
      end else begin
         key = $urandom;
      end
      send_beat(kind, key);
   endtask

   task automatic run_phase(input int send_pct, input int rcv_pct, input int span,
                            input bit with_pressure);
      int n;
      int k;
      send_idle_pct = send_pct;
      rsp_idle_pct  <= rcv_pct;
      pool_span     = span;
      for (n = 0; n < PHASE_ITEMS; n++) begin
         if (with_pressure && n == 40) begin
            // stall the response side while requests keep coming
            send_idle_pct = 0;
            hold_requests <= hold_requests + 1;
            for (k = 0; k < 24; k++) begin
               send_random_item();
            end
            send_idle_pct = send_pct;
         end
         if (with_pressure && n == 100) begin
            wait_drained();
         end
         send_random_item();
      end
      wait_drained();
   endtask

   function automatic logic [REQ_KEY_W-1:0] fill_key(input int idx);
      return 32'h1000_0000 + idx * 32'h0101_0101;
   endfunction

   initial begin
      int i;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty, duplicates, missing keys, full set, gap closing
      send_beat(REQ_DUMP, $urandom);
      send_beat(REQ_ADD, '0);
      send_beat(REQ_ADD, '1);
      send_beat(REQ_ADD, '0);
      send_beat(REQ_CONTAINS, '1);
      send_beat(REQ_CONTAINS, 32'h0000_0001);
      send_beat(REQ_REMOVE, 32'h0000_0001);
      for (i = 0; i < SET_CAPACITY - 2; i++) begin
         send_beat(REQ_ADD, fill_key(i));
      end
      send_beat(REQ_ADD, 32'h1234_5678);
      send_beat(REQ_ADD, '1);
      send_beat(REQ_DUMP, $urandom);
      send_beat(REQ_REMOVE, fill_key(5));
      send_beat(REQ_DUMP, $urandom);
      send_beat(REQ_REMOVE, '0);
      wait_drained();

      run_phase(33, 52, 12, 1'b1);
      run_phase(52, 33, POOL_SIZE, 1'b0);
      run_phase(0, 0, 20, 1'b0);

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
